// ===== hdl/bpg_pkg.sv =====
// ----------------------------------------------------------------------------
// bpg_pkg: shared types and constants of the bitmap pixel to gray unit
// Holds the word layouts of both queue sides, the register map, the command
// and pixel format codes and the default sizes handed to the top level.
// ----------------------------------------------------------------------------
package bpg_pkg;

	// Defaults for the top level parameters.
	localparam int unsigned PALETTE_DEPTH_DEF = 256;
	localparam int unsigned MAX_WIDTH_DEF     = 4096;

	// Depths of the internal queues.
	localparam int unsigned MID_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 8;

	// Configuration port geometry.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 4;

	// Field widths.
	localparam int unsigned FMT_W   = 2;
	localparam int unsigned WIDTH_W = 13;
	localparam int unsigned XS_W    = 12;
	localparam int unsigned RGB_W   = 24;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned GRAY_W  = 8;

	typedef enum logic [1:0] {
		REG_PIXEL_FORMAT = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_X_START      = 2'd2,
		REG_COLOR_MODE   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		FMT_INDEXED  = 2'd0,
		FMT_RGB555   = 2'd1,
		FMT_RGB888   = 2'd2,
		FMT_RGBA8888 = 2'd3
	} pix_fmt_t;

	typedef enum logic {
		CMD_PIXEL     = 1'b0,
		CMD_PAL_WRITE = 1'b1
	} cmd_t;

	// Input word.
	typedef struct packed {
		logic               cmd;
		logic [31:0]        pixel_data;
		logic [IDX_W-1:0]   palette_index;
		logic [RGB_W-1:0]   palette_rgb;
	} bpg_in_t;

	// Result word.
	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic              row_end;
	} bpg_out_t;

	// Configuration write request.
	typedef struct packed {
		logic              en;
		reg_idx_t          idx;
		logic [DATA_W-1:0] data;
	} cfg_wr_t;

	// Configuration register contents.
	typedef struct packed {
		pix_fmt_t           pixel_format;
		logic [WIDTH_W-1:0] image_width;
		logic [XS_W-1:0]    x_start;
		logic               color_mode;
	} cfg_t;

	// Classified item passed from the front to the back.
	typedef struct packed {
		logic             is_wr;    // palette write, no result
		logic             lookup;   // convert through the palette
		logic             halve;    // colour subcolumn
		logic             row_end;
		logic [IDX_W-1:0] idx;      // palette address
		logic [RGB_W-1:0] rgb;      // written colour or direct colour
	} mid_t;

endpackage

// ===== hdl/bmp_pixel_to_gray_unit.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_to_gray_unit: bitmap pixel to 8-bit gray level converter
// Queue-style input and result sides, APB-style configuration port.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while full is low and gives one result
// per clock while results are ready and pop is high: a word is accepted
// when push is high and full is low, and every pixel word yields one gray
// result while palette write words yield none. A pixel is turned into red,
// green and blue by the pixel format register (palette lookup, RGB555
// widened by three bits, or RGB888 with any fourth byte ignored) and gray
// is (299R + 587G + 114B + 500) / 1000. With color mode set, every panel
// column whose position modulo 3 is two gets its gray halved; the phase
// starts each row at x_start and follows the column counter, which wraps at
// the image width and raises row_end on the last pixel of a row. Accepted
// words pass a four-entry queue, then a four-stage back end (palette read,
// channel weights, rounded sum, reciprocal multiply for the divide) and an
// eight-entry result queue. The palette is a single-port memory of
// PALETTE_DEPTH entries with no reset; lookups of entries never written
// return undefined colour. Registers sit at byte addresses 0, 4, 8 and 12
// (pixel format, image width, x start, color mode); the user must write
// them only while no words are in flight, which the unit does not enforce.
// ----------------------------------------------------------------------------
module bmp_pixel_to_gray_unit #(
	parameter int unsigned PALETTE_DEPTH = bpg_pkg::PALETTE_DEPTH_DEF,
	parameter int unsigned MAX_WIDTH     = bpg_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input side
	input  bpg_pkg::bpg_in_t           item,
	input  logic                       push,
	output logic                       full,
	// result side
	output bpg_pkg::bpg_out_t          result,
	output logic                       empty,
	input  logic                       pop,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bpg_pkg::ADDR_W-1:0] paddr,
	input  logic [bpg_pkg::DATA_W-1:0] pwdata,
	output logic [bpg_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	bpg_pkg::cfg_wr_t cfg_wr;
	bpg_pkg::cfg_t    cfg;
	bpg_pkg::mid_t    entry;
	bpg_pkg::mid_t    head;
	bpg_pkg::reg_idx_t rd_idx;
	logic             accept;
	logic             head_empty;
	logic             head_pop;

	// The port never waits; a write lands on the access cycle.
	assign pready      = 1'b1;
	assign cfg_wr.en   = psel && penable && pwrite && pready;
	assign cfg_wr.idx  = bpg_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr.data = pwdata;
	assign rd_idx      = bpg_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (rd_idx)
			bpg_pkg::REG_PIXEL_FORMAT: prdata = bpg_pkg::DATA_W'(cfg.pixel_format);
			bpg_pkg::REG_IMAGE_WIDTH:  prdata = bpg_pkg::DATA_W'(cfg.image_width);
			bpg_pkg::REG_X_START:      prdata = bpg_pkg::DATA_W'(cfg.x_start);
			bpg_pkg::REG_COLOR_MODE:   prdata = bpg_pkg::DATA_W'(cfg.color_mode);
			default:                   prdata = '0;
		endcase
	end

	// A word is taken whenever the middle queue has room.
	assign accept = push && !full;

	bpg_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_wr),
		.cfg   (cfg),
		.accept(accept),
		.item  (item),
		.entry (entry)
	);

	// Middle queue: lets the front keep taking words while the back waits.
	bpg_queue #(
		.WIDTH($bits(bpg_pkg::mid_t)),
		.DEPTH(bpg_pkg::MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_data(entry),
		.rd_en  (head_pop),
		.rd_data(head),
		.full   (full),
		.empty  (head_empty),
		.count  ()
	);

	bpg_back #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_empty(head_empty),
		.head_pop  (head_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== hdl/bpg_queue.sv =====
// ----------------------------------------------------------------------------
// bpg_queue: small first-in first-out queue
// Register array with read and write pointers and a fill count; the head
// word is shown combinationally while the queue is not empty.
// ----------------------------------------------------------------------------
module bpg_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/bpg_front.sv =====
// ----------------------------------------------------------------------------
// bpg_front: configuration registers and item classification
// Holds the registers, the column counter and the modulo-3 panel phase,
// decodes direct colour formats and builds the word for the back end.
// ----------------------------------------------------------------------------
module bpg_front #(
	parameter int unsigned MAX_WIDTH = bpg_pkg::MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bpg_pkg::cfg_wr_t cfg_wr,
	output bpg_pkg::cfg_t    cfg,
	input  logic             accept,
	input  bpg_pkg::bpg_in_t item,
	output bpg_pkg::mid_t    entry
);

	localparam int unsigned CNT_W = $clog2(MAX_WIDTH);
	localparam int unsigned MW_W  = $clog2(MAX_WIDTH+1);
	localparam int unsigned EW    = (bpg_pkg::WIDTH_W > MW_W) ? bpg_pkg::WIDTH_W : MW_W;
	localparam int unsigned CW    = (EW > CNT_W+1) ? EW : CNT_W+1;

	// Remainder by three: base-4 digits sum to the same residue.
	function automatic logic [1:0] mod3(input logic [31:0] v);
		logic [5:0] s1;
		logic [3:0] s2;
		s1 = '0;
		for (int i = 0; i < 16; i++) begin
			s1 = s1 + 6'(v[2*i +: 2]);
		end
		s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
		if (s2 >= 4'd9) begin
			s2 = s2 - 4'd9;
		end else if (s2 >= 4'd6) begin
			s2 = s2 - 4'd6;
		end else if (s2 >= 4'd3) begin
			s2 = s2 - 4'd3;
		end
		return s2[1:0];
	endfunction

	bpg_pkg::cfg_t   cfg_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       phase_q;
	logic [1:0]       xs_mod3_q;

	logic [CW-1:0]    w_ext;
	logic [CW-1:0]    eff_w;
	logic [CW-1:0]    count_inc;
	logic             last;
	logic [7:0]       b0;
	logic [7:0]       b1;
	logic [7:0]       b2;
	logic [bpg_pkg::XS_W-1:0] xs_new;

	assign cfg = cfg_q;
	assign b0  = item.pixel_data[7:0];
	assign b1  = item.pixel_data[15:8];
	assign b2  = item.pixel_data[23:16];
	assign xs_new = cfg_wr.data[bpg_pkg::XS_W-1:0];

	always_comb begin
		w_ext     = CW'(cfg_q.image_width);
		count_inc = CW'(count_q) + CW'(1);
		if (w_ext == '0) begin
			eff_w = CW'(1);
		end else if (w_ext > CW'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = w_ext;
		end
		last = (count_inc >= eff_w);
	end

	always_comb begin
		entry.is_wr   = (item.cmd == bpg_pkg::CMD_PAL_WRITE);
		entry.lookup  = (cfg_q.pixel_format == bpg_pkg::FMT_INDEXED);
		entry.halve   = cfg_q.color_mode && (phase_q == 2'd2);
		entry.row_end = last;
		entry.idx     = b0;
		unique case (cfg_q.pixel_format)
			bpg_pkg::FMT_RGB555: begin
				entry.rgb = {b0[6:2], 3'b000, b0[1:0], b1[7:5], 3'b000,
					b1[4:0], 3'b000};
			end
			bpg_pkg::FMT_INDEXED, bpg_pkg::FMT_RGB888, bpg_pkg::FMT_RGBA8888: begin
				entry.rgb = {b0, b1, b2};
			end
			default: begin
				entry.rgb = {b0, b1, b2};
			end
		endcase
		if (item.cmd == bpg_pkg::CMD_PAL_WRITE) begin
			entry.idx = item.palette_index;
			entry.rgb = item.palette_rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= bpg_pkg::FMT_INDEXED;
			cfg_q.image_width  <= bpg_pkg::WIDTH_W'(1);
			cfg_q.x_start      <= '0;
			cfg_q.color_mode   <= 1'b0;
			count_q            <= '0;
			phase_q            <= 2'd0;
			xs_mod3_q          <= 2'd0;
		end else begin
			if (cfg_wr.en) begin
				unique case (cfg_wr.idx)
					bpg_pkg::REG_PIXEL_FORMAT: begin
						cfg_q.pixel_format <= bpg_pkg::pix_fmt_t'(cfg_wr.data[1:0]);
					end
					bpg_pkg::REG_IMAGE_WIDTH: begin
						cfg_q.image_width <= cfg_wr.data[bpg_pkg::WIDTH_W-1:0];
					end
					bpg_pkg::REG_X_START: begin
						cfg_q.x_start <= xs_new;
						xs_mod3_q     <= mod3(32'(xs_new));
						phase_q       <= mod3(32'(xs_new) + 32'(count_q));
					end
					bpg_pkg::REG_COLOR_MODE: begin
						cfg_q.color_mode <= cfg_wr.data[0];
					end
					default: begin
					end
				endcase
			end else if (accept && item.cmd == bpg_pkg::CMD_PIXEL) begin
				if (last) begin
					count_q <= '0;
					phase_q <= xs_mod3_q;
				end else begin
					count_q <= count_inc[CNT_W-1:0];
					phase_q <= (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
				end
			end
		end
	end

endmodule

// ===== hdl/bpg_back.sv =====
// ----------------------------------------------------------------------------
// bpg_back: palette, luma datapath and result queue
// Takes classified words from the middle queue, reads or writes the palette,
// forms the weighted sum, divides by 1000 and queues the gray results.
// ----------------------------------------------------------------------------
module bpg_back #(
	parameter int unsigned PALETTE_DEPTH = bpg_pkg::PALETTE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bpg_pkg::mid_t     head,
	input  logic              head_empty,
	output logic              head_pop,
	output bpg_pkg::bpg_out_t result,
	output logic              empty,
	input  logic              pop
);

	localparam int unsigned PAL_AW = $clog2(PALETTE_DEPTH);
	localparam int unsigned OCW    = $clog2(bpg_pkg::OUT_DEPTH+1);
	localparam int unsigned CRW    = OCW + 1;
	// Division by 1000 as a multiply by ceil(2^28/1000) for sums below 2^18.
	localparam logic [18:0] DIV_RECIP = 19'd268436;
	localparam int unsigned DIV_SHIFT = 28;

	logic [bpg_pkg::RGB_W-1:0] pal_mem [PALETTE_DEPTH];

	logic                      in_range;
	logic                      credit_ok;
	logic [OCW-1:0]            out_count;
	logic [2:0]                inflight;
	logic                      out_full;

	// Stage 1: palette data and direct colour.
	logic                      v_s1;
	logic [bpg_pkg::RGB_W-1:0] pal_rd_s1;
	logic [bpg_pkg::RGB_W-1:0] rgb_s1;
	logic                      use_pal_s1;
	logic                      pal_hit_s1;
	logic                      halve_s1;
	logic                      row_end_s1;
	logic [bpg_pkg::RGB_W-1:0] col_s1;

	// Stage 2: weighted channels.
	logic                      v_s2;
	logic [16:0]               pr_s2;
	logic [17:0]               pg_s2;
	logic [14:0]               pb_s2;
	logic                      halve_s2;
	logic                      row_end_s2;

	// Stage 3: rounded sum.
	logic                      v_s3;
	logic [17:0]               sum_s3;
	logic                      halve_s3;
	logic                      row_end_s3;

	// Stage 4: quotient.
	logic                      v_s4;
	logic [36:0]               prod;
	logic [7:0]                quo_s4;
	logic                      halve_s4;
	logic                      row_end_s4;

	bpg_pkg::bpg_out_t         out_word;

	assign in_range = ({1'b0, head.idx} < 9'(PALETTE_DEPTH));
	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign credit_ok = (CRW'(out_count) + CRW'(inflight)) < CRW'(bpg_pkg::OUT_DEPTH);
	assign head_pop = !head_empty && (head.is_wr || credit_ok);

	always_ff @(posedge clk) begin
		if (head_pop && head.is_wr && in_range) begin
			pal_mem[head.idx[PAL_AW-1:0]] <= head.rgb;
		end
		if (head_pop && !head.is_wr && head.lookup) begin
			pal_rd_s1 <= pal_mem[head.idx[PAL_AW-1:0]];
		end
	end

	always_comb begin
		if (!use_pal_s1) begin
			col_s1 = rgb_s1;
		end else if (pal_hit_s1) begin
			col_s1 = pal_rd_s1;
		end else begin
			col_s1 = '0;
		end
	end

	assign prod = {18'd0, sum_s3} * {18'd0, DIV_RECIP};

	always_ff @(posedge clk) begin
		rgb_s1     <= head.rgb;
		use_pal_s1 <= head.lookup;
		pal_hit_s1 <= in_range;
		halve_s1   <= head.halve;
		row_end_s1 <= head.row_end;

		pr_s2      <= 17'(col_s1[23:16]) * 17'd299;
		pg_s2      <= 18'(col_s1[15:8]) * 18'd587;
		pb_s2      <= 15'(col_s1[7:0]) * 15'd114;
		halve_s2   <= halve_s1;
		row_end_s2 <= row_end_s1;

		sum_s3     <= 18'(pr_s2) + pg_s2 + 18'(pb_s2) + 18'd500;
		halve_s3   <= halve_s2;
		row_end_s3 <= row_end_s2;

		quo_s4     <= prod[DIV_SHIFT +: 8];
		halve_s4   <= halve_s3;
		row_end_s4 <= row_end_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= head_pop && !head.is_wr;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		out_word.gray    = halve_s4 ? {1'b0, quo_s4[7:1]} : quo_s4;
		out_word.row_end = row_end_s4;
	end

	// Credits keep this queue from ever refusing a finished word.
	bpg_queue #(
		.WIDTH($bits(bpg_pkg::bpg_out_t)),
		.DEPTH(bpg_pkg::OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (v_s4),
		.wr_data(out_word),
		.rd_en  (pop),
		.rd_data(result),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	logic unused_full;
	assign unused_full = out_full;

endmodule
